>>> rtl/lphs_pkg.sv
// Shared types and constants for the linear probe hash set.
// No dependencies; imported by every other file of the block.
package lphs_pkg;

    localparam int SLOTS     = 256;
    localparam int KEY_BITS  = 32;
    localparam int HASH_W    = 32;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CAP_W     = IDX_W + 1;
    localparam int CNT_W     = IDX_W + 1;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = HASH_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(SLOTS);

    typedef enum logic [1:0] {
        KIND_FIND   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PROBE,
        S_COMMIT,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        OUT_MATCH,
        OUT_FREE,
        OUT_NONE
    } outcome_t;

    typedef struct packed {
        logic                rd_en;
        logic [IDX_W-1:0]    rd_addr;
        logic                wr_en;
        logic [IDX_W-1:0]    wr_addr;
        logic                wr_used;
        logic [KEY_BITS-1:0] wr_key;
        logic                clr;
    } mem_req_t;

    typedef struct packed {
        logic                valid;
        logic                used;
        logic [KEY_BITS-1:0] key;
    } mem_rd_t;

endpackage

>>> rtl/lphs_if.sv
// Handshake channels of the linear probe hash set: request, response, config.
// Depends on lphs_pkg.
interface lphs_in_if import lphs_pkg::*;;
    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [31:0]       key;
    logic [HASH_W-1:0] hash;

    modport source (output valid, kind, key, hash, input ready);
    modport sink   (input valid, kind, key, hash, output ready);
endinterface

interface lphs_out_if import lphs_pkg::*;;
    logic             valid;
    logic             ready;
    status_t          status;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] count;

    modport source (output valid, status, slot, count, input ready);
    modport sink   (input valid, status, slot, count, output ready);
endinterface

interface lphs_cfg_if import lphs_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

>>> rtl/lphs_mod.sv
// Iterative remainder unit: hash modulo capacity, four dividend bits a cycle.
// Depends on lphs_pkg.
module lphs_mod import lphs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [CAP_W-1:0]  divisor,
    output logic              done,
    output logic [IDX_W-1:0]  rem
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [HASH_W-1:0] num_reg;
    logic [CAP_W-1:0]  den_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  rem_next;

    always_comb
    begin
        logic [CAP_W-1:0] r;
        r = CAP_W'(rem_reg);
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r = {r[IDX_W-1:0], num_reg[HASH_W-1-i]};
            if (r >= den_reg)
            begin
                r = r - den_reg;
            end
        end
        rem_next = r[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << DIV_BITS;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

>>> rtl/lphs_mem.sv
// Slot store: one synchronous key/used memory plus per-slot valid flops.
// An invalid slot reads as empty. Depends on lphs_pkg.
module lphs_mem import lphs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output mem_rd_t  rd
);

    logic [KEY_BITS:0]  mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg;
    logic               rd_valid_reg;
    logic [KEY_BITS:0]  rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= {req.wr_used, req.wr_key};
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.used  = rd_data_reg[KEY_BITS];
    assign rd.key   = rd_data_reg[KEY_BITS-1:0];

endmodule

>>> rtl/linear_probe_hash_set.sv
// Top level of the linear probe hash set: control sequencer and count.
// Depends on lphs_pkg, lphs_if, lphs_mod, lphs_mem.
//
//   channel  dir  payload                      accepted when
//   req      in   kind, key, hash              req.valid && req.ready
//   rsp      out  status, slot, count          rsp.valid && rsp.ready
//   cfg      in   capacity                     cfg.valid && cfg.ready
//
// One item at a time: accept, remainder, first read, one probe read per slot, then
// commit and response; clear, and finds and removes on an empty set, skip the
// remainder and probe.
// The probe loop reads one slot per cycle from the slot memory.
// Reset empties all slots, zeroes count and sets capacity to 256 at once.
// A result waiting on rsp does not block the next accept; the result after it
// holds in the response state until rsp takes the waiting one.
module linear_probe_hash_set import lphs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lphs_in_if.sink    req,
    lphs_out_if.source rsp,
    lphs_cfg_if.sink   cfg
);

    state_t              state_reg, state_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [CAP_W-1:0]    cap_eff;
    logic [CNT_W-1:0]    count_reg, count_next;
    kind_t               kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                have_tomb_reg;
    logic [IDX_W-1:0]    tomb_reg;
    logic [IDX_W-1:0]    pidx_reg;
    logic [CNT_W-1:0]    n_reg;
    outcome_t            outcome_reg;
    logic [IDX_W-1:0]    where_reg;
    status_t             res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [IDX_W-1:0]    out_slot_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic                accept;
    logic                need_probe;
    logic                div_start;
    logic                div_done;
    logic [IDX_W-1:0]    div_rem;
    mem_req_t            mem_req;
    mem_rd_t             mem_rd;
    logic [IDX_W-1:0]    nxt_idx;
    logic                probe_stop;
    outcome_t            probe_outcome;
    logic [IDX_W-1:0]    probe_where;
    logic                tomb_here;
    logic                resp_load;

    assign cap_eff = (cap_reg == '0) ? CAP_W'(1)
                   : (cap_reg > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : cap_reg;

    assign accept     = req.valid && req.ready;
    assign need_probe = (req.kind == KIND_INSERT)
                     || ((req.kind != KIND_CLEAR) && (count_reg != '0));
    assign resp_load  = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    lphs_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.hash),
        .divisor  (cap_eff),
        .done     (div_done),
        .rem      (div_rem)
    );

    lphs_mem u_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rd    (mem_rd)
    );

    // probe evaluation of the slot whose data arrives this cycle
    always_comb
    begin
        nxt_idx = ((CAP_W'(pidx_reg) + 1'b1) == cap_eff) ? '0 : pidx_reg + 1'b1;
        tomb_here     = mem_rd.valid && !mem_rd.used;
        probe_stop    = 1'b0;
        probe_outcome = OUT_NONE;
        probe_where   = '0;
        if (!mem_rd.valid)
        begin
            probe_stop    = 1'b1;
            probe_outcome = OUT_FREE;
            probe_where   = have_tomb_reg ? tomb_reg : pidx_reg;
        end
        else if (mem_rd.used && (mem_rd.key == key_reg))
        begin
            probe_stop    = 1'b1;
            probe_outcome = OUT_MATCH;
            probe_where   = pidx_reg;
        end
        else if ((n_reg + 1'b1) == cap_eff)
        begin
            probe_stop = 1'b1;
            if (have_tomb_reg || tomb_here)
            begin
                probe_outcome = OUT_FREE;
                probe_where   = have_tomb_reg ? tomb_reg : pidx_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_probe ? S_DIV : S_COMMIT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (probe_stop)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (resp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready         = (state_reg == S_IDLE);
        div_start         = accept && need_probe;
        mem_req           = '0;
        mem_req.wr_addr   = where_reg;
        mem_req.wr_key    = key_reg;
        count_next        = count_reg;
        res_status_next   = STAT_MISS;
        res_slot_next     = '0;
        unique case (state_reg)
            S_DIV:
            begin
                mem_req.rd_en   = div_done;
                mem_req.rd_addr = div_rem;
            end
            S_PROBE:
            begin
                mem_req.rd_en   = !probe_stop;
                mem_req.rd_addr = nxt_idx;
            end
            S_COMMIT:
            begin
                unique case (kind_reg)
                    KIND_CLEAR:
                    begin
                        mem_req.clr     = 1'b1;
                        count_next      = '0;
                        res_status_next = STAT_OK;
                    end
                    KIND_INSERT:
                    begin
                        if (outcome_reg == OUT_NONE)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            res_status_next = STAT_OK;
                            res_slot_next   = where_reg;
                            if (outcome_reg == OUT_FREE)
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_used = 1'b1;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (outcome_reg == OUT_MATCH)
                        begin
                            res_status_next = STAT_OK;
                            res_slot_next   = where_reg;
                            mem_req.wr_en   = 1'b1;
                            count_next      = count_reg - 1'b1;
                        end
                    end
                    KIND_FIND:
                    begin
                        if (outcome_reg == OUT_MATCH)
                        begin
                            res_status_next = STAT_OK;
                            res_slot_next   = where_reg;
                        end
                    end
                    default:
                    begin
                        res_status_next = STAT_MISS;
                    end
                endcase
            end
            default:
            begin
                mem_req.rd_en = 1'b0;
            end
        endcase
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.capacity;
            end
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= req.kind;
            key_reg       <= req.key;
            have_tomb_reg <= 1'b0;
            outcome_reg   <= OUT_NONE;
            where_reg     <= '0;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            pidx_reg <= div_rem;
            n_reg    <= '0;
        end
        if (state_reg == S_PROBE)
        begin
            if (tomb_here && !have_tomb_reg)
            begin
                have_tomb_reg <= 1'b1;
                tomb_reg      <= pidx_reg;
            end
            if (probe_stop)
            begin
                outcome_reg <= probe_outcome;
                where_reg   <= probe_where;
            end
            else
            begin
                pidx_reg <= nxt_idx;
                n_reg    <= n_reg + 1'b1;
            end
        end
        if (state_reg == S_COMMIT)
        begin
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
        end
        if (resp_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.slot   = out_slot_reg;
    assign rsp.count  = out_count_reg;

    a_wr_in_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.wr_en || mem_req.clr) |-> (state_reg == S_COMMIT))
        else $error("slot store written outside commit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("occupied count above slot count");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (n_reg < cap_eff))
        else $error("probe ran past capacity");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder finished outside divide state");

endmodule
